### rtl/flp_pkg.sv
package flp_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 18;
    localparam int STATE_W  = 32;

    // Fixed-point shifts
    localparam int Q_SHIFT    = 5;
    localparam int P_FRAC     = 17;
    localparam int R_FRAC     = 16;
    localparam int SQ_SHIFT   = 31;
    localparam int CUBE_SHIFT = 23;

    // Datapath widths
    localparam int MA_W   = STATE_W + 1;
    localparam int MUL_W  = 2 * STATE_W + 1;
    localparam int K_W    = COEF_W + 2;
    localparam int SQ_W   = STATE_W + 1;
    localparam int MO_W   = STATE_W + 1;

    // Division of the cube by six: halve, then divide by three by splitting
    // the dividend and multiplying the small part by a reciprocal
    localparam int CLIP_DIV   = 6;
    localparam int DIV_BY     = CLIP_DIV / 2;
    localparam int DIV_W      = 40;
    localparam int DIV_SPLIT  = 20;
    localparam int DIV3_SH    = 22;

    localparam int N_SECT   = 4;
    localparam int SEC_W    = $clog2(N_SECT);

    localparam logic [COEF_W-1:0] P_ONE = 18'd131072;

    // Sample queue between front and back
    localparam int FLP_QDEPTH = 2;

    // Configuration port
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_GAIN_P = 1'b0;
    localparam logic REG_RES_R  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [STATE_W-1:0]  t_state;

    typedef struct packed {
        logic idle;
        logic out_full;
    } t_back_stat;

endpackage

### rtl/flp_if.sv
interface flp_in_if import flp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface flp_out_if import flp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/four_pole_ladder_lowpass.sv
// Resonant four-pole ladder lowpass for a stream of signed Q1.22 audio samples.
// Samples arrive on i_in and one filtered, soft-clipped sample leaves on o_out
// for each of them; both channels move one sample per valid/ready transfer.
// The section gain p (Q1.17) and the resonance r (Q2.16) are written over the
// APB-style port at byte addresses 0 and 4; the user must write them only
// while no sample is in flight, as the block itself does not enforce this.
// The arithmetic back end owns the single shared 33 x 32 multiplier and the
// divide-by-three unit, and it takes no new sample from the queue until it
// has finished the last one.
// The front end takes a sample and places it in a small queue, so up to
// QDEPTH + 1 samples can be taken while the back end is busy.
// When the receiver stalls, the finished sample waits in the output register;
// the back end meanwhile computes the next sample and holds in its final
// step, and i_in.ready falls once the queue and the front are full.
// Reset clears the filter state, both coefficients and every handshake.
module four_pole_ladder_lowpass import flp_pkg::*; #(
    parameter int QDEPTH = FLP_QDEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    flp_in_if.sink            i_in,
    flp_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [COEF_W-1:0] w_gain_p;
    logic [COEF_W-1:0] w_res_r;

    // Front end to queue
    logic   f_vld;
    logic   f_rdy;
    t_state f_data;

    // Queue to back end
    logic   q_vld;
    logic   q_rdy;
    t_state q_data;

    t_back_stat w_stat;

    flp_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_gain_p (w_gain_p),
        .o_res_r  (w_res_r)
    );

    // The front end widens each sample to the internal format.
    flp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_push_vld  (f_vld),
        .i_push_rdy  (f_rdy),
        .o_push_data (f_data)
    );

    // The queue lets the front end keep taking samples during a computation.
    flp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (f_vld),
        .o_push_rdy  (f_rdy),
        .i_push_data (f_data),
        .o_pop_vld   (q_vld),
        .i_pop_rdy   (q_rdy),
        .o_pop_data  (q_data)
    );

    // The back end runs the feedback, the four sections and the clipper in
    // sequence and presents the result in its output register.
    flp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_vld  (q_vld),
        .o_pop_rdy  (q_rdy),
        .i_pop_data (q_data),
        .i_gain_p   (w_gain_p),
        .i_res_r    (w_res_r),
        .o_out      (o_out),
        .o_stat     (w_stat)
    );

    // Taking a sample from the queue must start a computation.
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_vld && q_rdy) |=> !w_stat.idle)
        else $error("back end stayed idle after taking a sample");

    // A result appears only when a computation has just finished.
    a_out_from_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!w_stat.idle))
        else $error("output became valid without a finished computation");

    // A sample refused by the queue stays unchanged in the front end.
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_vld && !f_rdy) |=> (f_vld && $stable(f_data)))
        else $error("front end lost or changed a waiting sample");

endmodule

### rtl/flp_cfg.sv
module flp_cfg import flp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic [COEF_W-1:0]   o_gain_p,
    output logic [COEF_W-1:0]   o_res_r
);

    logic              w_wr;
    logic [COEF_W-1:0] r_gain_p;
    logic [COEF_W-1:0] r_res_r;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_res_r  <= '0;
        end else if (w_wr) begin
            case (paddr[REG_IDX_BIT])
                REG_GAIN_P: r_gain_p <= pwdata[COEF_W-1:0];
                REG_RES_R:  r_res_r  <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_IDX_BIT])
            REG_GAIN_P: prdata = APB_DW'(r_gain_p);
            REG_RES_R:  prdata = APB_DW'(r_res_r);
            default:    prdata = '0;
        endcase
    end

    assign o_gain_p = r_gain_p;
    assign o_res_r  = r_res_r;

endmodule

### rtl/flp_front.sv
module flp_front import flp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    flp_in_if.sink i_in,
    output logic   o_push_vld,
    input  logic   i_push_rdy,
    output t_state o_push_data
);

    logic   r_vld;
    t_state r_data;
    t_state n_data;

    // The sample is widened to the internal Q4.27 format on entry.
    assign n_data     = t_state'(STATE_W'(i_in.sample_in) <<< Q_SHIFT);
    assign i_in.ready = !r_vld || i_push_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= n_data;
        end
    end

    assign o_push_vld  = r_vld;
    assign o_push_data = r_data;

endmodule

### rtl/flp_queue.sv
module flp_queue import flp_pkg::*; #(
    parameter int DEPTH = FLP_QDEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_vld,
    output logic   o_push_rdy,
    input  t_state i_push_data,
    output logic   o_pop_vld,
    input  logic   i_pop_rdy,
    output t_state o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_push_rdy = (r_cnt != CW'(DEPTH));
    assign o_pop_vld  = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rp];
    assign w_wr       = i_push_vld && o_push_rdy;
    assign w_rd       = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

### rtl/flp_back.sv
module flp_back import flp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_vld,
    output logic              o_pop_rdy,
    input  t_state            i_pop_data,
    input  logic [COEF_W-1:0] i_gain_p,
    input  logic [COEF_W-1:0] i_res_r,
    flp_out_if.source         o_out,
    output t_back_stat        o_stat
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FB   = 4'd1;
    localparam logic [3:0] ST_SMUL = 4'd2;
    localparam logic [3:0] ST_SEND = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_SQR  = 4'd5;
    localparam logic [3:0] ST_CUBE = 4'd6;
    localparam logic [3:0] ST_CR   = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam int DIV_HI_W = DIV_W - DIV_SPLIT;
    localparam int DIV_B_W  = DIV_SPLIT + 1;
    localparam int DIV_P_W  = 2 * DIV_B_W;

    localparam logic [DIV_W-1:0]   DIV3_HI = DIV_W'(((1 << DIV_SPLIT) - 1) / DIV_BY);
    localparam logic [DIV_P_W-1:0] DIV3_M  = DIV_P_W'(((1 << DIV3_SH) + 2) / DIV_BY);

    localparam logic signed [MUL_W-1:0] HALF_R  = MUL_W'(1) << (R_FRAC - 1);
    localparam logic signed [MUL_W-1:0] HALF_P  = MUL_W'(1) << (P_FRAC - 1);
    localparam logic signed [MUL_W-1:0] HALF_SQ = MUL_W'(1) << (SQ_SHIFT - 1);
    localparam logic signed [MUL_W-1:0] HALF_CU = MUL_W'(1) << (CUBE_SHIFT - 1);
    localparam logic signed [MUL_W-1:0] BIAS_D  = MUL_W'(DIV_BY);
    localparam logic signed [MUL_W-1:0] SAT_HI  = (MUL_W'(1) << (STATE_W - 1)) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] SAT_LO  = -(MUL_W'(1) << (STATE_W - 1));
    localparam logic signed [MO_W-1:0]  HALF_O  = MO_W'(1) << (Q_SHIFT - 1);
    localparam logic signed [MO_W-1:0]  OUT_HI  = (MO_W'(1) << (SAMPLE_W - 1)) - MO_W'(1);
    localparam logic signed [MO_W-1:0]  OUT_LO  = -(MO_W'(1) << (SAMPLE_W - 1));

    function automatic t_state sat_state(input logic signed [MUL_W-1:0] v);
        t_state res;
        if (v > SAT_HI) begin
            res = {1'b0, {(STATE_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            res = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            res = v[STATE_W-1:0];
        end
        return res;
    endfunction

    logic [3:0]              r_st;
    logic [3:0]              n_st;
    logic [SEC_W-1:0]        r_sec;
    logic [SEC_W-1:0]        w_nsec;
    t_state                  r_so [N_SECT];
    t_state                  r_sp [N_SECT];
    t_state                  r_cur;
    t_state                  r_y;
    logic signed [SQ_W-1:0]  r_sq;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [MUL_W-1:0] r_acc;
    logic [DIV_W-1:0]        r_div;
    logic                    r_neg;
    logic                    r_out_vld;
    t_sample                 r_out;

    logic signed [MA_W-1:0]    m_a;
    logic signed [STATE_W-1:0] m_b;
    logic signed [MUL_W-1:0]   m_p;
    logic signed [STATE_W-1:0] w_p;
    logic signed [K_W-1:0]     w_k;
    logic signed [STATE_W-1:0] w_r;

    logic signed [MUL_W-1:0] w_fb;
    logic signed [MUL_W-1:0] w_sec;
    logic signed [MUL_W-1:0] w_cube;
    logic signed [MUL_W-1:0] w_mag;
    logic signed [MUL_W-1:0] w_q;
    logic signed [MUL_W-1:0] w_clip;
    logic signed [MO_W-1:0]  w_o;
    t_sample                 w_osat;
    logic [DIV_HI_W-1:0]     w_ah;
    logic [DIV_SPLIT-1:0]    w_al;
    logic [DIV_B_W-1:0]      w_b;
    logic [DIV_P_W-1:0]      w_bm;
    logic [DIV_W-1:0]        w_div;
    logic                    w_out_free;

    // Coefficients: p and r are non-negative, k = 2p - 1 in Q2.17.
    assign w_p    = STATE_W'($signed({1'b0, i_gain_p}));
    assign w_r    = STATE_W'($signed({1'b0, i_res_r}));
    assign w_k    = $signed({1'b0, i_gain_p, 1'b0}) - $signed(K_W'(P_ONE));
    assign w_nsec = r_sec + SEC_W'(1);

    // The one shared multiplier; its operands follow the sequencer state.
    always_comb begin
        case (r_st)
            ST_IDLE: begin
                m_a = MA_W'(r_so[N_SECT-1]);
                m_b = w_r;
            end
            ST_FB: begin
                m_a = MA_W'(r_so[0]);
                m_b = STATE_W'(w_k);
            end
            ST_SMUL: begin
                m_a = MA_W'(r_cur) + MA_W'(r_sp[r_sec]);
                m_b = w_p;
            end
            ST_SEND: begin
                m_a = MA_W'(r_so[w_nsec]);
                m_b = STATE_W'(w_k);
            end
            ST_SQ: begin
                m_a = MA_W'(r_y);
                m_b = r_y;
            end
            ST_CUBE: begin
                m_a = r_sq;
                m_b = r_y;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = MUL_W'(m_a) * MUL_W'(m_b);

    assign w_fb   = MUL_W'(r_cur) - ((r_prod + HALF_R) >>> R_FRAC);
    assign w_sec  = (r_prod - r_acc + HALF_P) >>> P_FRAC;
    assign w_cube = (r_prod + HALF_CU) >>> CUBE_SHIFT;
    assign w_mag  = (w_cube[MUL_W-1] ? -w_cube : w_cube) + BIAS_D;
    assign w_q    = MUL_W'(r_div);
    assign w_clip = MUL_W'(r_y) - (r_neg ? -w_q : w_q);
    assign w_o    = (MO_W'(r_so[N_SECT-1]) + HALF_O) >>> Q_SHIFT;

    always_comb begin
        if (w_o > OUT_HI) begin
            w_osat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (w_o < OUT_LO) begin
            w_osat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            w_osat = w_o[SAMPLE_W-1:0];
        end
    end

    // Division by three in one step. Since 2^20 = 3 * 349525 + 1, the high
    // part contributes hi * 349525 to the quotient and hi itself to the
    // remainder sum; that sum, below 2^21, is divided exactly by a
    // multiplication with ceil(2^22 / 3) and a shift.
    assign w_ah  = r_div[DIV_W-1:DIV_SPLIT];
    assign w_al  = r_div[DIV_SPLIT-1:0];
    assign w_b   = DIV_B_W'(w_ah) + DIV_B_W'(w_al);
    assign w_bm  = DIV_P_W'(w_b) * DIV3_M;
    assign w_div = DIV_W'(w_ah) * DIV3_HI + DIV_W'(w_bm >> DIV3_SH);

    assign w_out_free = !r_out_vld || o_out.ready;

    always_comb begin
        case (r_st)
            ST_IDLE: n_st = i_pop_vld ? ST_FB : ST_IDLE;
            ST_FB:   n_st = ST_SMUL;
            ST_SMUL: n_st = ST_SEND;
            ST_SEND: n_st = (r_sec == SEC_W'(N_SECT - 1)) ? ST_SQ : ST_SMUL;
            ST_SQ:   n_st = ST_SQR;
            ST_SQR:  n_st = ST_CUBE;
            ST_CUBE: n_st = ST_CR;
            ST_CR:   n_st = ST_DIV;
            ST_DIV:  n_st = ST_FIN;
            ST_FIN:  n_st = ST_OUT;
            ST_OUT:  n_st = w_out_free ? ST_IDLE : ST_OUT;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_sec     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_FB:   r_sec <= '0;
                ST_SEND: r_sec <= w_nsec;
                default: ;
            endcase
            if (r_st == ST_OUT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Filter state is cleared by reset; the rest is working storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_SECT; i++) begin
                r_so[i] <= '0;
                r_sp[i] <= '0;
            end
        end else begin
            case (r_st)
                ST_SEND: begin
                    r_sp[r_sec] <= r_cur;
                    if (r_sec != SEC_W'(N_SECT - 1)) begin
                        r_so[r_sec] <= sat_state(w_sec);
                    end
                end
                ST_FIN:  r_so[N_SECT-1] <= sat_state(w_clip);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_cur  <= i_pop_data;
                r_prod <= m_p;
            end
            ST_FB: begin
                r_cur <= sat_state(w_fb);
                r_acc <= m_p;
            end
            ST_SMUL: r_prod <= m_p;
            ST_SEND: begin
                r_cur <= sat_state(w_sec);
                r_y   <= sat_state(w_sec);
                r_acc <= m_p;
            end
            ST_SQ:   r_prod <= m_p;
            ST_SQR:  r_sq <= SQ_W'((r_prod + HALF_SQ) >>> SQ_SHIFT);
            ST_CUBE: r_prod <= m_p;
            ST_CR: begin
                r_neg <= w_cube[MUL_W-1];
                r_div <= w_mag[DIV_W:1];
            end
            ST_DIV:  r_div <= w_div;
            ST_OUT: begin
                if (w_out_free) begin
                    r_out <= w_osat;
                end
            end
            default: ;
        endcase
    end

    assign o_pop_rdy        = (r_st == ST_IDLE);
    assign o_out.valid      = r_out_vld;
    assign o_out.sample_out = r_out;
    assign o_stat.idle      = (r_st == ST_IDLE);
    assign o_stat.out_full  = r_out_vld;

endmodule
